>>> rtl/latency_percentile_summary_core_defines.svh
// ----------------------------------------------------------------------------
// latency_percentile_summary_core_defines.svh
// Assertion macros used by the percentile summary core.
// ----------------------------------------------------------------------------
`ifndef LATENCY_PERCENTILE_SUMMARY_CORE_DEFINES_SVH
`define LATENCY_PERCENTILE_SUMMARY_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// condition in the same cycle
`define LPS_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("lps assertion failed");

// condition in the following cycle
`define LPS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("lps assertion failed");

`else

`define LPS_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`define LPS_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

>>> rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, constants and percentile table of the percentile summary core.
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int LPS_MAX_SAMPLES = 1024;
	localparam int SAMPLE_W        = 64;
	localparam int COUNT_W         = 11;

	// percentiles in hundredths of a percent
	localparam int          Q_W       = 14;
	localparam logic [13:0] Q_ROUND   = 14'd9999;
	localparam logic [13:0] Q_DIVISOR = 14'd10000;

	// pick slots: five percentiles then the maximum
	localparam int         PICK_NUM  = 6;
	localparam logic [2:0] PICK_P50  = 3'd0;
	localparam logic [2:0] PICK_P90  = 3'd1;
	localparam logic [2:0] PICK_P99  = 3'd2;
	localparam logic [2:0] PICK_P999 = 3'd3;
	localparam logic [2:0] PICK_P9999 = 3'd4;
	localparam logic [2:0] PICK_MAX  = 3'd5;

	// sorter status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} lps_sort_stat_t;

	function automatic logic [13:0] pct_q(input logic [2:0] slot);
		logic [13:0] q;
		case (slot)
			PICK_P50:   q = 14'd5000;
			PICK_P90:   q = 14'd9000;
			PICK_P99:   q = 14'd9900;
			PICK_P999:  q = 14'd9990;
			PICK_P9999: q = 14'd9999;
			default:    q = 14'd0;
		endcase
		return q;
	endfunction

endpackage

>>> rtl/lps_rank_div.sv
// ----------------------------------------------------------------------------
// lps_rank_div
// Division by the fixed rank divisor through a registered reciprocal multiply.
// ----------------------------------------------------------------------------
module lps_rank_div import lps_pkg::*; #(
	parameter int NW = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	output logic          done,
	output logic [NW-1:0] quo
);

	// reciprocal ceil(2^RSH / divisor) is exact for every NW-bit dividend
	localparam int RSH = NW + Q_W;
	localparam int MW  = NW + 1;
	localparam int PW  = NW + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << RSH) + 64'(Q_DIVISOR) - 64'd1) / 64'(Q_DIVISOR));

	logic [NW-1:0] num_q;
	logic [PW-1:0] prod_q;
	logic          step_q;
	logic          done_q;

	// dividend register, then the product
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
		end
		if (step_q) begin
			prod_q <= PW'(num_q) * PW'(RECIP);
		end
	end

	// strobe chain alongside the dividend and product registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			step_q <= start;
			done_q <= step_q;
		end
	end

	assign done = done_q;
	assign quo  = {{(Q_W-1){1'b0}}, prod_q[PW-1:RSH]};

endmodule

>>> rtl/lps_sorter.sv
// ----------------------------------------------------------------------------
// lps_sorter
// Sample memory with an in-place insertion sort around one 64-bit comparator.
// ----------------------------------------------------------------------------
module lps_sorter import lps_pkg::*; #(
	parameter int MAX_SAMPLES = LPS_MAX_SAMPLES,
	parameter int AW          = 10,
	parameter int CW          = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	// sample loading
	input  logic                load_we,
	input  logic [AW-1:0]       load_addr,
	input  logic [SAMPLE_W-1:0] load_data,
	// sort control
	input  logic                sort_start,
	input  logic [CW-1:0]       sort_n,
	output lps_sort_stat_t      sort_stat,
	// pick reads after the sort
	input  logic                pick_re,
	input  logic [AW-1:0]       pick_addr,
	output logic [SAMPLE_W-1:0] rd_data
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_KEY   = 5'b00010,
		S_LDKEY = 5'b00100,
		S_CMP   = 5'b01000,
		S_PLACE = 5'b10000
	} sort_state_t;

	logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic [SAMPLE_W-1:0] rd_data_q;

	sort_state_t         state_q, state_d;
	logic [AW-1:0]       i_q, i_d;
	logic [AW-1:0]       j_q, j_d;
	logic [CW-1:0]       n_q, n_d;
	logic [SAMPLE_W-1:0] v_q, v_d;
	logic                done_q, done_d;

	logic                sort_we;
	logic [AW-1:0]       sort_wa;
	logic [SAMPLE_W-1:0] sort_wd;
	logic                sort_re;
	logic [AW-1:0]       sort_ra;
	logic                key_less;

	logic                mem_we;
	logic [AW-1:0]       mem_wa;
	logic [SAMPLE_W-1:0] mem_wd;
	logic                mem_re;
	logic [AW-1:0]       mem_ra;

	// the shared comparator: held key against the word just read
	assign key_less = v_q < rd_data_q;

	// sort sequencer
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		n_d     = n_q;
		v_d     = v_q;
		done_d  = 1'b0;
		sort_we = 1'b0;
		sort_wa = j_q;
		sort_wd = v_q;
		sort_re = 1'b0;
		sort_ra = i_q;
		unique case (state_q)
			S_IDLE: begin
				if (sort_start) begin
					n_d = sort_n;
					if (sort_n <= CW'(1)) begin
						done_d = 1'b1;
					end else begin
						i_d     = AW'(1);
						state_d = S_KEY;
					end
				end
			end
			S_KEY: begin
				sort_re = 1'b1;
				sort_ra = i_q;
				state_d = S_LDKEY;
			end
			S_LDKEY: begin
				v_d     = rd_data_q;
				j_d     = i_q;
				sort_re = 1'b1;
				sort_ra = i_q - 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (key_less) begin
					// move the larger word up one slot
					sort_we = 1'b1;
					sort_wa = j_q;
					sort_wd = rd_data_q;
					j_d     = j_q - 1'b1;
					if (j_q != AW'(1)) begin
						sort_re = 1'b1;
						sort_ra = j_q - AW'(2);
					end else begin
						state_d = S_PLACE;
					end
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				sort_we = 1'b1;
				sort_wa = j_q;
				sort_wd = v_q;
				if (CW'(i_q) + 1'b1 == n_q) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_KEY;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		n_q <= n_d;
		v_q <= v_d;
	end

	// memory port selection
	assign mem_we = load_we | sort_we;
	assign mem_wa = sort_we ? sort_wa : load_addr;
	assign mem_wd = sort_we ? sort_wd : load_data;
	assign mem_re = pick_re | sort_re;
	assign mem_ra = sort_re ? sort_ra : pick_addr;

	// sample memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	assign rd_data        = rd_data_q;
	assign sort_stat.busy = (state_q != S_IDLE);
	assign sort_stat.done = done_q;

endmodule

>>> rtl/latency_percentile_summary_core.sv
// ----------------------------------------------------------------------------
// latency_percentile_summary_core
// Nearest-rank percentile summary (p50..p99.99, max, count) of a sample set.
// ----------------------------------------------------------------------------
// Samples are taken one word per cycle and written straight into the sample
// memory. The word with tlast closes the set; the input then stays not ready
// while the set is sorted in place by an insertion sort that shares one 64-bit
// comparator and the memory's read and write ports: each key is read, compared
// against the words below it, each larger word is moved up one slot, and the
// key is placed. Each of the five percentile ranks then is divided by 10000
// with a reciprocal multiply and takes one memory read; the maximum takes one
// memory read alone. An empty set skips the sort and the picks. The summary
// leaves through an output register, and a new set is taken as soon as the
// summary is registered. Samples beyond MAX_SAMPLES are dropped and flagged
// in m_tuser. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "latency_percentile_summary_core_defines.svh"

module latency_percentile_summary_core import lps_pkg::*; #(
	parameter int MAX_SAMPLES = LPS_MAX_SAMPLES
) (
	input  logic         clk,
	input  logic         arst_n,
	// sample words
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // [63:0] sample_value
	input  logic         s_tuser,   // [0] has_sample
	input  logic         s_tlast,   // last_item
	// summary words
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [399:0] m_tdata,   // [10:0] sample_count, [74:11] pct_50,
	                                // [138:75] pct_90, [202:139] pct_99,
	                                // [266:203] pct_99_9, [330:267] pct_99_99,
	                                // [394:331] max_value, [399:395] zero
	output logic         m_tuser    // [0] overflowed
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int NW = CW + Q_W;

	typedef enum logic [6:0] {
		T_LOAD  = 7'b0000001,
		T_START = 7'b0000010,
		T_SORT  = 7'b0000100,
		T_DIV   = 7'b0001000,
		T_DIVW  = 7'b0010000,
		T_CAP   = 7'b0100000,
		T_OUT   = 7'b1000000
	} top_state_t;

	top_state_t          state_q;
	logic [CW-1:0]       count_q;
	logic                ovf_q;
	logic [2:0]          k_q;
	logic [SAMPLE_W-1:0] res_q [PICK_NUM];

	logic                m_tvalid_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [SAMPLE_W-1:0] out_val_q [PICK_NUM];
	logic                out_ovf_q;

	logic                in_acc;
	logic                room;
	logic                load_we;
	logic                out_free;
	logic [CW-1:0]       n_m1;
	logic [NW-1:0]       div_num;
	logic                div_start;
	logic                div_done;
	logic [NW-1:0]       div_quo;
	logic [CW-1:0]       rank_idx;
	logic                pick_re;
	logic [AW-1:0]       pick_addr;
	logic                sort_start;
	lps_sort_stat_t      sort_stat;
	logic [SAMPLE_W-1:0] rd_data;
	logic [CW+COUNT_W-1:0] count_ext;

	// input handshake and sample write
	assign s_tready = (state_q == T_LOAD);
	assign in_acc   = s_tvalid & s_tready;
	assign room     = count_q < CW'(MAX_SAMPLES);
	assign load_we  = in_acc & s_tuser & room;
	assign out_free = ~m_tvalid_q | m_tready;
	assign n_m1     = count_q - 1'b1;

	// rank numerator n*q + 9999, ceiling division follows
	assign div_num = NW'(count_q) * NW'(pct_q(k_q)) + NW'(Q_ROUND);

	// rank index from quotient, minus one and clamped to n-1
	always_comb begin
		if (div_quo == '0) begin
			rank_idx = '0;
		end else if (div_quo > NW'(count_q)) begin
			rank_idx = n_m1;
		end else begin
			rank_idx = CW'(div_quo - 1'b1);
		end
	end

	// sequencer strobes
	always_comb begin
		sort_start = 1'b0;
		div_start  = 1'b0;
		pick_re    = 1'b0;
		pick_addr  = rank_idx[AW-1:0];
		unique case (state_q)
			T_START: begin
				sort_start = (count_q != '0);
			end
			T_DIV: begin
				if (k_q == PICK_MAX) begin
					pick_re   = 1'b1;
					pick_addr = n_m1[AW-1:0];
				end else begin
					div_start = 1'b1;
				end
			end
			T_DIVW: begin
				pick_re = div_done;
			end
			T_LOAD, T_SORT, T_CAP, T_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_LOAD;
			count_q    <= '0;
			ovf_q      <= 1'b0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// summary word held until taken
			m_tvalid_q <= ((state_q == T_OUT) && out_free) || (m_tvalid_q && !m_tready);
			unique case (state_q)
				T_LOAD: begin
					if (in_acc) begin
						if (s_tuser) begin
							if (room) begin
								count_q <= count_q + 1'b1;
							end else begin
								ovf_q <= 1'b1;
							end
						end
						if (s_tlast) begin
							state_q <= T_START;
						end
					end
				end
				T_START: begin
					state_q <= (count_q == '0) ? T_OUT : T_SORT;
				end
				T_SORT: begin
					if (sort_stat.done) begin
						k_q     <= PICK_P50;
						state_q <= T_DIV;
					end
				end
				T_DIV: begin
					state_q <= (k_q == PICK_MAX) ? T_CAP : T_DIVW;
				end
				T_DIVW: begin
					if (div_done) begin
						state_q <= T_CAP;
					end
				end
				T_CAP: begin
					if (k_q == PICK_MAX) begin
						state_q <= T_OUT;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= T_DIV;
					end
				end
				T_OUT: begin
					if (out_free) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= T_LOAD;
					end
				end
				default: begin
					state_q <= T_LOAD;
				end
			endcase
		end
	end

	// picked values, cleared for an empty set
	always_ff @(posedge clk) begin
		if (state_q == T_START && count_q == '0) begin
			for (int p = 0; p < PICK_NUM; p++) begin
				res_q[p] <= '0;
			end
		end else if (state_q == T_CAP) begin
			res_q[k_q] <= rd_data;
		end
	end

	// output register
	assign count_ext = {{COUNT_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (state_q == T_OUT && out_free) begin
			out_count_q <= count_ext[COUNT_W-1:0];
			out_ovf_q   <= ovf_q;
			for (int p = 0; p < PICK_NUM; p++) begin
				out_val_q[p] <= res_q[p];
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_ovf_q;
	assign m_tdata  = {5'b0, out_val_q[PICK_MAX], out_val_q[PICK_P9999],
	                   out_val_q[PICK_P999], out_val_q[PICK_P99], out_val_q[PICK_P90],
	                   out_val_q[PICK_P50], out_count_q};

	lps_sorter #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.AW          (AW),
		.CW          (CW)
	) u_sorter (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_we    (load_we),
		.load_addr  (count_q[AW-1:0]),
		.load_data  (s_tdata),
		.sort_start (sort_start),
		.sort_n     (count_q),
		.sort_stat  (sort_stat),
		.pick_re    (pick_re),
		.pick_addr  (pick_addr),
		.rd_data    (rd_data)
	);

	lps_rank_div #(
		.NW (NW)
	) u_rank_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sort completes only while the sequencer waits for it
	`LPS_ASSERT_IMPL(a_sort_done_state, clk, arst_n, sort_stat.done, state_q == T_SORT)
	// a quotient is ready only while the sequencer waits for it
	`LPS_ASSERT_IMPL(a_div_done_state, clk, arst_n, div_done, state_q == T_DIVW)
	// dropped samples only once the store is full
	`LPS_ASSERT_IMPL(a_ovf_full, clk, arst_n, ovf_q, count_q == CW'(MAX_SAMPLES))
	// sorter is idle whenever samples are loaded
	`LPS_ASSERT_IMPL(a_load_idle, clk, arst_n, load_we, !sort_stat.busy)

endmodule
